@@ sv/fscpd_pkg.sv @@
// fscpd_pkg: shared types and codes of the fast sc polar decoder
`default_nettype none

package fscpd_pkg;

	// request codes of an input item
	localparam logic [2:0] REQ_F    = 3'd0;
	localparam logic [2:0] REQ_G    = 3'd1;
	localparam logic [2:0] REQ_LLR  = 3'd2;
	localparam logic [2:0] REQ_KIND = 3'd3;
	localparam logic [2:0] REQ_FRZ  = 3'd4;
	localparam logic [2:0] REQ_SYM  = 3'd5;

	// node kinds; anything above KIND_SPC is an inner node
	localparam logic [2:0] KIND_R0  = 3'd0;
	localparam logic [2:0] KIND_R1  = 3'd1;
	localparam logic [2:0] KIND_REP = 3'd2;
	localparam logic [2:0] KIND_SPC = 3'd3;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [6:0]  node_index;
		logic [5:0]  position;
		logic [2:0]  level;
		logic        partial_bit;
		logic [3:0]  sym_a;
		logic [3:0]  sym_b;
		logic signed [15:0] entry_value;
		logic        last;
	} item_t;

	typedef struct packed {
		logic        message_bit;
		logic [5:0]  bit_index;
		logic        last_res;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NODE,
		ST_KIND,
		ST_SP_RD1,
		ST_SP_RD2,
		ST_SP_ACC,
		ST_SP_REP,
		ST_SP_FLIP,
		ST_UP,
		ST_FG_RD1,
		ST_FG_RD2,
		ST_FG_WR,
		ST_FG_LEAF,
		ST_CB_RD,
		ST_CB_W1,
		ST_CB_W2,
		ST_EN_RD,
		ST_EN_WR,
		ST_LS_RD,
		ST_LS_CK,
		ST_EM_RD,
		ST_EM_CK
	} state_t;

endpackage

`default_nettype wire

@@ sv/fscpd_ram.sv @@
// fscpd_ram: generic ram, one write port, two registered read ports
`default_nettype none

module fscpd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

@@ sv/fast_sc_polar_decoder_lut.sv @@
// fast_sc_polar_decoder_lut: table driven fast sc polar decoder, top level
//
//   channel | dir | payload  | handshake
//   --------+-----+----------+-------------------------------
//   item    | in  | item_t   | item_valid / item_stall
//   result  | out | result_t | result_valid / result_stall
//
// loads (f, g, llr, node kind, frozen, channel symbol) are taken only while idle.
// a channel symbol with last starts the decode; item_stall stays high until
// the last result is in the output register. the walk is set by the memory
// ports: each node visit reads the node kind; a special node reads, sums and
// writes each element (then a repetition pass on rep, a flip for an odd spc);
// f/g elements are read and written; combine writes both halves per pair;
// then come re-encoding, the frozen scan and emission, which waits on result_stall.
// reset clears the control state only; tables hold garbage until loaded.
`default_nettype none

module fast_sc_polar_decoder_lut import fscpd_pkg::*; #(
	parameter int CODE_LENGTH   = 64,
	parameter int SYMBOL_LEVELS = 16,
	parameter int LLR_WIDTH     = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire item_t item,
	input  wire logic item_valid,
	output logic      item_stall,
	output result_t   result,
	output logic      result_valid,
	input  wire logic result_stall
);

	localparam int LOG2N    = $clog2(CODE_LENGTH);
	localparam int HALF_N   = CODE_LENGTH / 2;
	localparam int NODES    = 2 * CODE_LENGTH - 1;
	localparam int SQ       = SYMBOL_LEVELS * SYMBOL_LEVELS;
	localparam int F_DEPTH  = LOG2N * HALF_N * SQ;
	localparam int G_DEPTH  = 2 * F_DEPTH;
	localparam int L_DEPTH  = LOG2N * CODE_LENGTH * SYMBOL_LEVELS;
	localparam int S_DEPTH  = (LOG2N + 1) * CODE_LENGTH;
	localparam int FA       = $clog2(F_DEPTH);
	localparam int GA       = $clog2(G_DEPTH);
	localparam int LA       = $clog2(L_DEPTH);
	localparam int SA       = $clog2(S_DEPTH);
	localparam int KA       = $clog2(NODES);
	localparam int SW       = $clog2(SYMBOL_LEVELS);
	localparam int LVW      = (LLR_WIDTH < 16) ? LLR_WIDTH : 16;
	localparam int SUMW     = LVW + LOG2N + 1;
	localparam int DW       = $clog2(LOG2N + 1);
	localparam int PW       = (LOG2N > 1) ? $clog2(LOG2N) : 1;
	localparam int IW       = LOG2N + 1;

	// ---------------------------------------------------------------
	// state
	// ---------------------------------------------------------------
	state_t st_q, st_d;

	logic [DW-1:0]   d_q;        // current tree depth
	logic [LOG2N-1:0] k_q;       // node index within depth
	logic [1:0]      prog_q [LOG2N]; // progress of each node on the path
	logic [IW-1:0]   i_q;        // element / pair / bit counter
	logic [DW-1:0]   e_q;        // re-encode stage

	logic signed [SUMW-1:0] sum_q;
	logic [LVW:0]    minabs_q;
	logic [IW-1:0]   minpos_q;
	logic            parity_q;
	logic            hdmin_q;
	logic [2:0]      kind_q;
	logic            right_q;
	logic            rb_q;
	logic [IW-1:0]   last_q;
	logic            any_q;
	result_t         res_q;
	logic            res_valid_q;

	// ---------------------------------------------------------------
	// memories
	// ---------------------------------------------------------------
	logic          f_we, g_we, l_we, k_we, z_we, s_we, b_we;
	logic [FA-1:0] f_wa, f_ra;
	logic [GA-1:0] g_wa, g_ra;
	logic [LA-1:0] l_wa, l_ra;
	logic [KA-1:0] k_wa, k_ra;
	logic [LOG2N-1:0] z_wa, z_ra;
	logic [SA-1:0] s_wa, s_ra0, s_ra1, b_wa, b_ra0, b_ra1;
	logic [SW-1:0] f_wd, g_wd, s_wd, f_rd, g_rd, s_rd0, s_rd1;
	logic [LVW-1:0] l_wd, l_rd;
	logic [2:0]    k_wd, k_rd;
	logic          z_wd, z_rd, b_wd, b_rd0, b_rd1;

	fscpd_ram #(.WIDTH(SW), .DEPTH(F_DEPTH)) u_f_ram (
		.clk, .we(f_we), .waddr(f_wa), .wdata(f_wd),
		.raddr_a(f_ra), .rdata_a(f_rd), .raddr_b(f_ra), .rdata_b()
	);
	fscpd_ram #(.WIDTH(SW), .DEPTH(G_DEPTH)) u_g_ram (
		.clk, .we(g_we), .waddr(g_wa), .wdata(g_wd),
		.raddr_a(g_ra), .rdata_a(g_rd), .raddr_b(g_ra), .rdata_b()
	);
	fscpd_ram #(.WIDTH(LVW), .DEPTH(L_DEPTH)) u_llr_ram (
		.clk, .we(l_we), .waddr(l_wa), .wdata(l_wd),
		.raddr_a(l_ra), .rdata_a(l_rd), .raddr_b(l_ra), .rdata_b()
	);
	fscpd_ram #(.WIDTH(3), .DEPTH(NODES)) u_kind_ram (
		.clk, .we(k_we), .waddr(k_wa), .wdata(k_wd),
		.raddr_a(k_ra), .rdata_a(k_rd), .raddr_b(k_ra), .rdata_b()
	);
	fscpd_ram #(.WIDTH(1), .DEPTH(CODE_LENGTH)) u_frz_ram (
		.clk, .we(z_we), .waddr(z_wa), .wdata(z_wd),
		.raddr_a(z_ra), .rdata_a(z_rd), .raddr_b(z_ra), .rdata_b()
	);
	fscpd_ram #(.WIDTH(SW), .DEPTH(S_DEPTH)) u_sym_ram (
		.clk, .we(s_we), .waddr(s_wa), .wdata(s_wd),
		.raddr_a(s_ra0), .rdata_a(s_rd0), .raddr_b(s_ra1), .rdata_b(s_rd1)
	);
	fscpd_ram #(.WIDTH(1), .DEPTH(S_DEPTH)) u_bit_ram (
		.clk, .we(b_we), .waddr(b_wa), .wdata(b_wd),
		.raddr_a(b_ra0), .rdata_a(b_rd0), .raddr_b(b_ra1), .rdata_b(b_rd1)
	);

	// ---------------------------------------------------------------
	// load address decode
	// ---------------------------------------------------------------
	logic        item_xfer;
	logic [7:0]  ld_p1;
	logic [2:0]  ld_dep;
	logic [31:0] ld_half, ld_off, ld_slot, ld_fa, ld_ga, ld_la;
	logic        ld_fg_ok, ld_llr_ok;
	logic [SW-1:0] val_sym, sa_sym;

	assign item_stall = (st_q != ST_IDLE);
	assign item_xfer  = item_valid && !item_stall;

	always_comb begin
		ld_p1  = {1'b0, item.node_index} + 8'd1;
		ld_dep = 3'd0;
		for (int j = 0; j < 8; j++) begin
			if (ld_p1[j]) begin
				ld_dep = 3'(j);
			end
		end
		ld_half = 32'(CODE_LENGTH) >> (32'(ld_dep) + 32'd1);
		ld_off  = 32'(item.node_index) - ((32'd1 << ld_dep) - 32'd1);
		ld_slot = (32'(ld_dep) << (LOG2N - 1)) + (ld_off << (LOG2N - 32'(ld_dep) - 1));
		ld_fa   = ((ld_slot + 32'(item.position)) * SYMBOL_LEVELS + 32'(item.sym_a))
			* SYMBOL_LEVELS + 32'(item.sym_b);
		ld_ga   = ((((ld_slot + 32'(item.position)) << 1) + 32'(item.partial_bit))
			* SYMBOL_LEVELS + 32'(item.sym_a)) * SYMBOL_LEVELS + 32'(item.sym_b);
		ld_la   = (((32'(item.level) << LOG2N) + 32'(item.position)) * SYMBOL_LEVELS)
			+ 32'(item.sym_a);
		ld_fg_ok = (32'(item.node_index) < 32'(CODE_LENGTH - 1))
			&& (32'(item.sym_a) < 32'(SYMBOL_LEVELS))
			&& (32'(item.sym_b) < 32'(SYMBOL_LEVELS))
			&& (32'(item.position) < ld_half);
		ld_llr_ok = (32'(item.level) < 32'(LOG2N))
			&& (32'(item.position) < 32'(CODE_LENGTH))
			&& (32'(item.sym_a) < 32'(SYMBOL_LEVELS));
		// saturate loaded symbols to the symbol range
		if (item.entry_value < 0) begin
			val_sym = '0;
		end else if (32'(item.entry_value) >= 32'(SYMBOL_LEVELS)) begin
			val_sym = SW'(SYMBOL_LEVELS - 1);
		end else begin
			val_sym = item.entry_value[SW-1:0];
		end
		if (32'(item.sym_a) >= 32'(SYMBOL_LEVELS)) begin
			sa_sym = SW'(SYMBOL_LEVELS - 1);
		end else begin
			sa_sym = SW'(item.sym_a);
		end
	end

	// ---------------------------------------------------------------
	// walk address generation
	// ---------------------------------------------------------------
	logic [31:0] dd, kk, ii, temp_a, half_a, base_a, lbits_a, slot_a, ck_a;
	logic [31:0] csym_a, sp_la, leaf_la, fg_fa, fg_ga, ea, eb;
	logic [1:0]  prog_cur;
	logic        right_cur;
	logic signed [LVW-1:0] llr_v;
	logic signed [LVW:0]   llr_x;
	logic [LVW:0]          llr_abs;
	logic                  hd, take_min, parity_n, any_n;
	logic signed [SUMW-1:0] sum_n;
	logic                  res_free;

	always_comb begin
		dd        = 32'(d_q);
		kk        = 32'(k_q);
		ii        = 32'(i_q);
		prog_cur  = prog_q[d_q[PW-1:0]];
		right_cur = (prog_cur == 2'd1);
		temp_a    = 32'(CODE_LENGTH) >> dd;
		half_a    = temp_a >> 1;
		base_a    = (dd << LOG2N) + (kk << (LOG2N - dd));
		lbits_a   = ((dd + 32'd1) << LOG2N) + (kk << (LOG2N - dd));
		slot_a    = (dd << (LOG2N - 1)) + (kk << (LOG2N - dd - 1));
		ck_a      = (kk << 1) + 32'(right_q);
		csym_a    = ((dd + 32'd1) << LOG2N) + (ck_a << (LOG2N - dd - 1)) + ii;
		sp_la     = ((((dd == 32'd0) ? 32'd0 : (dd - 32'd1)) << LOG2N)
			+ (kk << (LOG2N - dd)) + ii) * SYMBOL_LEVELS + 32'(s_rd0);
		leaf_la   = ((32'(LOG2N - 1) << LOG2N) + ck_a) * SYMBOL_LEVELS + 32'(right_q ? g_rd : f_rd);
		fg_fa     = ((slot_a + ii) * SYMBOL_LEVELS + 32'(s_rd0)) * SYMBOL_LEVELS + 32'(s_rd1);
		fg_ga     = ((((slot_a + ii) << 1) + 32'(b_rd0)) * SYMBOL_LEVELS + 32'(s_rd0))
			* SYMBOL_LEVELS + 32'(s_rd1);
		// butterfly pair: insert a zero at bit e of the pair counter
		ea        = ((ii >> 32'(e_q)) << (32'(e_q) + 32'd1))
			| (ii & ((32'd1 << 32'(e_q)) - 32'd1));
		eb        = ea + (32'd1 << 32'(e_q));

		llr_v    = $signed(l_rd);
		llr_x    = (LVW+1)'(llr_v);
		llr_abs  = (llr_x < 0) ? (LVW+1)'(-llr_x) : (LVW+1)'(llr_x);
		hd       = (llr_v <= 0);
		sum_n    = sum_q + SUMW'(llr_v);
		take_min = (i_q == '0) || (llr_abs < minabs_q);
		parity_n = parity_q ^ hd;
		any_n    = any_q || !z_rd;
		res_free = !res_valid_q || !result_stall;
	end

	// ---------------------------------------------------------------
	// next state and memory strobes
	// ---------------------------------------------------------------
	always_comb begin
		st_d = st_q;
		f_we = 1'b0; f_wa = FA'(ld_fa); f_wd = val_sym;
		g_we = 1'b0; g_wa = GA'(ld_ga); g_wd = val_sym;
		l_we = 1'b0; l_wa = LA'(ld_la); l_wd = item.entry_value[LVW-1:0];
		k_we = 1'b0; k_wa = KA'(item.node_index); k_wd = item.entry_value[2:0];
		z_we = 1'b0; z_wa = LOG2N'(item.position); z_wd = (item.entry_value != 0);
		s_we = 1'b0; s_wa = SA'(item.position); s_wd = sa_sym;
		b_we = 1'b0; b_wa = SA'(base_a + ii); b_wd = 1'b0;

		f_ra  = FA'(fg_fa);
		g_ra  = GA'(fg_ga);
		l_ra  = (st_q == ST_FG_WR) ? LA'(leaf_la) : LA'(sp_la);
		k_ra  = KA'((32'd1 << dd) - 32'd1 + kk);
		z_ra  = (st_q == ST_FG_WR) ? LOG2N'(ck_a) : LOG2N'(ii);
		s_ra0 = SA'(base_a + ii);
		s_ra1 = SA'(base_a + half_a + ii);
		b_ra0 = SA'(lbits_a + ii);
		b_ra1 = SA'(lbits_a + half_a + ii);
		if (st_q == ST_EN_RD) begin
			b_ra0 = SA'(ea);
			b_ra1 = SA'(eb);
		end else if (st_q == ST_EM_RD) begin
			b_ra0 = SA'(ii);
		end

		unique case (st_q)
			ST_IDLE: begin
				if (item_xfer) begin
					unique case (item.req_type)
						REQ_F:    f_we = ld_fg_ok;
						REQ_G:    g_we = ld_fg_ok;
						REQ_LLR:  l_we = ld_llr_ok;
						REQ_KIND: k_we = (32'(item.node_index) < 32'(NODES));
						REQ_FRZ:  z_we = (32'(item.position) < 32'(CODE_LENGTH));
						REQ_SYM: begin
							s_we = (32'(item.position) < 32'(CODE_LENGTH));
							if (item.last) begin
								st_d = ST_NODE;
							end
						end
						default: ;
					endcase
				end
			end
			ST_NODE: begin
				if (dd != 32'(LOG2N)) begin
					st_d = ST_KIND;
				end
			end
			ST_KIND: begin
				if (prog_cur == 2'd0 && k_rd <= KIND_SPC) begin
					st_d = ST_SP_RD1;
				end else if (prog_cur <= 2'd1) begin
					st_d = ST_FG_RD1;
				end else begin
					st_d = ST_CB_RD;
				end
			end
			ST_SP_RD1: st_d = ST_SP_RD2;
			ST_SP_RD2: st_d = ST_SP_ACC;
			ST_SP_ACC: begin
				b_we = 1'b1;
				b_wd = (kind_q == KIND_R0) ? 1'b0 : hd;
				if (ii == temp_a - 32'd1) begin
					if (kind_q == KIND_REP) begin
						st_d = ST_SP_REP;
					end else if (kind_q == KIND_SPC && parity_n) begin
						st_d = ST_SP_FLIP;
					end else begin
						st_d = ST_UP;
					end
				end else begin
					st_d = ST_SP_RD1;
				end
			end
			ST_SP_REP: begin
				b_we = 1'b1;
				b_wd = (sum_q <= 0);
				if (ii == temp_a - 32'd1) begin
					st_d = ST_UP;
				end
			end
			ST_SP_FLIP: begin
				b_we = 1'b1;
				b_wa = SA'(base_a + 32'(minpos_q));
				b_wd = !hdmin_q;
				st_d = ST_UP;
			end
			ST_UP: begin
				st_d = (dd == 32'd0) ? ST_EN_RD : ST_NODE;
			end
			ST_FG_RD1: st_d = ST_FG_RD2;
			ST_FG_RD2: st_d = ST_FG_WR;
			ST_FG_WR: begin
				if (dd + 32'd1 < 32'(LOG2N)) begin
					s_we = 1'b1;
					s_wa = SA'(csym_a);
					s_wd = right_q ? g_rd : f_rd;
					st_d = (ii == half_a - 32'd1) ? ST_NODE : ST_FG_RD1;
				end else begin
					st_d = ST_FG_LEAF;
				end
			end
			ST_FG_LEAF: begin
				b_we = 1'b1;
				b_wa = SA'((32'(LOG2N) << LOG2N) + ck_a);
				b_wd = z_rd ? 1'b0 : hd;
				st_d = ST_NODE;
			end
			ST_CB_RD: st_d = ST_CB_W1;
			ST_CB_W1: begin
				b_we = 1'b1;
				b_wd = b_rd0 ^ b_rd1;
				st_d = ST_CB_W2;
			end
			ST_CB_W2: begin
				b_we = 1'b1;
				b_wa = SA'(base_a + half_a + ii);
				b_wd = rb_q;
				st_d = (ii == half_a - 32'd1) ? ST_UP : ST_CB_RD;
			end
			ST_EN_RD: st_d = ST_EN_WR;
			ST_EN_WR: begin
				b_we = 1'b1;
				b_wa = SA'(ea);
				b_wd = b_rd0 ^ b_rd1;
				if (ii == 32'(HALF_N - 1) && 32'(e_q) == 32'(LOG2N - 1)) begin
					st_d = ST_LS_RD;
				end else begin
					st_d = ST_EN_RD;
				end
			end
			ST_LS_RD: st_d = ST_LS_CK;
			ST_LS_CK: begin
				if (ii == 32'(CODE_LENGTH - 1)) begin
					st_d = any_n ? ST_EM_RD : ST_IDLE;
				end else begin
					st_d = ST_LS_RD;
				end
			end
			ST_EM_RD: st_d = ST_EM_CK;
			ST_EM_CK: begin
				if (z_rd || res_free) begin
					st_d = (ii == 32'(CODE_LENGTH - 1)) ? ST_IDLE : ST_EM_RD;
				end else begin
					st_d = ST_EM_RD;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			d_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			e_q         <= '0;
			res_valid_q <= 1'b0;
			for (int j = 0; j < LOG2N; j++) begin
				prog_q[j] <= 2'd0;
			end
		end else begin
			st_q <= st_d;
			// a new result may replace the one leaving in the same cycle
			if (st_q == ST_EM_CK && !z_rd && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (st_d == ST_NODE) begin
						d_q       <= '0;
						k_q       <= '0;
						prog_q[0] <= 2'd0;
					end
				end
				ST_NODE: begin
					// leaf level: climb back to the parent
					if (dd == 32'(LOG2N)) begin
						d_q <= d_q - 1'b1;
						k_q <= k_q >> 1;
					end
				end
				ST_KIND: i_q <= '0;
				ST_SP_ACC: begin
					i_q <= (st_d == ST_SP_RD1) ? i_q + 1'b1 : '0;
				end
				ST_SP_REP: i_q <= i_q + 1'b1;
				ST_UP: begin
					if (dd != 32'd0) begin
						d_q <= d_q - 1'b1;
						k_q <= k_q >> 1;
					end else begin
						i_q <= '0;
						e_q <= '0;
					end
				end
				ST_FG_WR, ST_FG_LEAF: begin
					if (st_d == ST_NODE) begin
						// descend into the child just computed
						prog_q[d_q[PW-1:0]] <= right_q ? 2'd2 : 2'd1;
						if (dd + 32'd1 < 32'(LOG2N)) begin
							prog_q[PW'(dd + 32'd1)] <= 2'd0;
						end
						d_q <= d_q + 1'b1;
						k_q <= LOG2N'(ck_a);
					end else if (st_d == ST_FG_RD1) begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_CB_W2: begin
					if (st_d == ST_UP) begin
						prog_q[d_q[PW-1:0]] <= 2'd3;
					end
					i_q <= i_q + 1'b1;
				end
				ST_EN_WR: begin
					if (ii == 32'(HALF_N - 1)) begin
						i_q <= '0;
						e_q <= e_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_LS_CK: begin
					i_q <= (ii == 32'(CODE_LENGTH - 1)) ? '0 : i_q + 1'b1;
				end
				ST_EM_CK: begin
					if (z_rd || res_free) begin
						i_q <= i_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// datapath registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (st_q)
			ST_KIND: begin
				kind_q   <= k_rd;
				right_q  <= right_cur;
				sum_q    <= '0;
				parity_q <= 1'b0;
			end
			ST_SP_ACC: begin
				sum_q    <= sum_n;
				parity_q <= parity_n;
				if (take_min) begin
					minabs_q <= llr_abs;
					minpos_q <= i_q;
					hdmin_q  <= hd;
				end
			end
			ST_CB_W1: rb_q <= b_rd1;
			ST_EN_WR: any_q <= 1'b0;
			ST_LS_CK: begin
				any_q <= any_n;
				if (!z_rd) begin
					last_q <= i_q;
				end
			end
			ST_EM_CK: begin
				if (!z_rd && res_free) begin
					res_q.message_bit <= b_rd0;
					res_q.bit_index   <= 6'(i_q);
					res_q.last_res    <= (i_q == last_q);
				end
			end
			default: ;
		endcase
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_k_in_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> ((32'(k_q) >> 32'(d_q)) == 32'd0))
		else $error("node index beyond its depth");

	a_res_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(st_q == ST_EM_CK))
		else $error("result raised outside emission");

	a_sp_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SP_ACC) |-> (32'(i_q) < temp_a))
		else $error("special node element counter overran");

	a_inner_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_KIND) |-> (32'(d_q) < 32'(LOG2N)))
		else $error("node visited at leaf depth");

endmodule

`default_nettype wire
